FILE: rtl/sampler_zone_resolver_assert.svh
// assertion macros for the zone resolver checker
`ifndef SAMPLER_ZONE_RESOLVER_ASSERT_SVH
`define SAMPLER_ZONE_RESOLVER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define SZR_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define SZR_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/szr_pkg.sv
// ----------------------------------------------------------------------------
// szr_pkg
// types and codes shared by the sampler zone resolver modules
// ----------------------------------------------------------------------------
package szr_pkg;

	typedef enum logic [1:0] {
		FN_WR_ZONE     = 2'd0,
		FN_WR_INST_RDY = 2'd1,
		FN_WR_INST_OFF = 2'd2,
		FN_RESOLVE     = 2'd3
	} func_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] index;
		logic [6:0] note;
		logic [6:0] velocity;
		logic [6:0] key_low;
		logic [6:0] key_high;
		logic [6:0] vel_min;
		logic [6:0] vel_max;
		logic [6:0] zone_root;
		logic [7:0] zone_sample;
		logic [7:0] first_zone;
		logic [7:0] zone_total;
	} req_beat_t;

	typedef struct packed {
		logic              found;
		logic [7:0]        zone_id;
		logic [7:0]        sample_id;
		logic [6:0]        root_out;
		logic signed [7:0] pitch_offset;
		logic [6:0]        layer_vel_low;
		logic [6:0]        layer_vel_high;
		logic [7:0]        layer_cnt;
		logic              single_layer;
	} rsp_beat_t;

	typedef struct packed {
		logic [6:0] key_low;
		logic [6:0] key_high;
		logic [6:0] vel_min;
		logic [6:0] vel_max;
		logic [6:0] root;
		logic [7:0] sample;
	} zone_ent_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] total;
		logic       ready;
	} inst_ent_t;

	typedef struct packed {
		logic       cov;
		logic       vel_ok;
		logic       root_eq;
		logic [6:0] root_dist;
	} zone_eval_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INST_RD,
		ST_SCAN1,
		ST_SCAN2,
		ST_DONE
	} state_t;

	localparam logic [7:0] CNT_MAX = 8'hff;

endpackage

FILE: rtl/szr_ram.sv
// ----------------------------------------------------------------------------
// szr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module szr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/szr_zone_eval.sv
// ----------------------------------------------------------------------------
// szr_zone_eval
// key cover, velocity cover, root distance and root match for one zone
// ----------------------------------------------------------------------------
module szr_zone_eval (
	input  szr_pkg::zone_ent_t  zone,
	input  logic [6:0]          note,
	input  logic [6:0]          velocity,
	input  logic [6:0]          sel_root,
	output szr_pkg::zone_eval_t ev
);

	import szr_pkg::*;

	always_comb begin
		ev.cov       = (note >= zone.key_low) && (note <= zone.key_high);
		ev.vel_ok    = (velocity >= zone.vel_min) && (velocity <= zone.vel_max);
		ev.root_eq   = (zone.root == sel_root);
		ev.root_dist = (zone.root > note) ? (zone.root - note) : (note - zone.root);
	end

endmodule

FILE: rtl/sampler_zone_resolver.sv
// ----------------------------------------------------------------------------
// sampler_zone_resolver
// zone and instrument tables with a key/velocity zone lookup per resolve beat
//
//   channel | dir | payload    | handshake
//   --------+-----+------------+---------------------
//   req     | in  | req_beat_t | req_valid/req_ready
//   rsp     | out | rsp_beat_t | rsp_valid/rsp_ready
//
// a write or a bad instrument id goes straight to the result. a resolve reads
// the instrument entry and stops there when it is not ready or its span is
// bad, stops after one pass when no zone covers the note, and else makes two
// passes over the zone ram, one read a cycle. one beat at a time; the next req
// beat is taken while a result waits in the rsp register, and a stalled rsp
// holds the following result back. reset clears all instruments to not ready.
// ----------------------------------------------------------------------------
module sampler_zone_resolver #(
	parameter int ZONES       = 256,
	parameter int INSTRUMENTS = 16,
	parameter int SAMPLES     = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  szr_pkg::req_beat_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output szr_pkg::rsp_beat_t rsp
);

	import szr_pkg::*;

	localparam int ZW = $clog2(ZONES);
	localparam int IW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;

	state_t state_q, state_d;

	logic req_acc;
	logic zone_idx_ok, inst_idx_ok;
	logic [INSTRUMENTS-1:0] inst_vld_q;
	logic ivld_q;

	inst_ent_t inst_wdata, inst_rdata;
	zone_ent_t zone_wdata, zone_rdata;

	logic [6:0] note_q, vel_q;
	logic [8:0] cnt_q, end_q, span_end;
	logic [7:0] start_q;
	logic inst_ok;
	logic rd_en, vld_s1, scan_done;
	logic [ZW-1:0] idx_s1;

	logic vel_hit_q, have_fb_q;
	zone_ent_t best_q, fb_q, sel_q;
	logic [ZW-1:0] best_id_q, fb_id_q, sel_id_q;
	logic [6:0] best_d_q, fb_d_q;
	logic [7:0] count_q;
	zone_eval_t ev;

	logic fail;
	rsp_beat_t res_q, res_ok;
	logic rsp_valid_q;
	rsp_beat_t rsp_q;
	logic rsp_load;

	assign req_ready   = (state_q == ST_IDLE);
	assign req_acc     = req_valid && req_ready;
	assign zone_idx_ok = ({1'b0, req.index} < 9'(ZONES));
	assign inst_idx_ok = ({1'b0, req.index} < 9'(INSTRUMENTS));

	assign inst_wdata.first = req.first_zone;
	assign inst_wdata.total = req.zone_total;
	assign inst_wdata.ready = (req.func == FN_WR_INST_RDY);

	assign zone_wdata.key_low  = req.key_low;
	assign zone_wdata.key_high = req.key_high;
	assign zone_wdata.vel_min  = req.vel_min;
	assign zone_wdata.vel_max  = req.vel_max;
	assign zone_wdata.root     = req.zone_root;
	assign zone_wdata.sample   = req.zone_sample;

	szr_ram #(
		.WIDTH ($bits(inst_ent_t)),
		.DEPTH (INSTRUMENTS)
	) u_inst_ram (
		.clk   (clk),
		.we    (req_acc && inst_idx_ok &&
		        (req.func == FN_WR_INST_RDY || req.func == FN_WR_INST_OFF)),
		.waddr (req.index[IW-1:0]),
		.wdata (inst_wdata),
		.re    (req_acc && (req.func == FN_RESOLVE)),
		.raddr (req.index[IW-1:0]),
		.rdata (inst_rdata)
	);

	assign rd_en     = (state_q == ST_SCAN1 || state_q == ST_SCAN2) && (cnt_q < end_q);
	assign scan_done = (cnt_q == end_q) && !vld_s1;

	szr_ram #(
		.WIDTH ($bits(zone_ent_t)),
		.DEPTH (ZONES)
	) u_zone_ram (
		.clk   (clk),
		.we    (req_acc && zone_idx_ok && (req.func == FN_WR_ZONE)),
		.waddr (req.index[ZW-1:0]),
		.wdata (zone_wdata),
		.re    (rd_en),
		.raddr (cnt_q[ZW-1:0]),
		.rdata (zone_rdata)
	);

	szr_zone_eval u_eval (
		.zone     (zone_rdata),
		.note     (note_q),
		.velocity (vel_q),
		.sel_root (sel_q.root),
		.ev       (ev)
	);

	assign span_end = {1'b0, inst_rdata.first} + {1'b0, inst_rdata.total};
	assign inst_ok  = ivld_q && inst_rdata.ready && (span_end <= 9'(ZONES)) &&
	                  (inst_rdata.total != 8'd0);

	assign fail = ({1'b0, sel_q.sample} >= 9'(SAMPLES)) ||
	              (!vel_hit_q && (count_q != 8'd1));

	always_comb begin
		res_ok.found          = 1'b1;
		res_ok.zone_id        = 8'(sel_id_q);
		res_ok.sample_id      = sel_q.sample;
		res_ok.root_out       = sel_q.root;
		res_ok.pitch_offset   = 8'({1'b0, note_q} - {1'b0, sel_q.root});
		res_ok.layer_vel_low  = sel_q.vel_min;
		res_ok.layer_vel_high = sel_q.vel_max;
		res_ok.layer_cnt      = count_q;
		res_ok.single_layer   = (count_q == 8'd1);
	end

	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_d = (req.func == FN_RESOLVE && inst_idx_ok) ? ST_INST_RD : ST_DONE;
				end
			end
			ST_INST_RD: begin
				state_d = inst_ok ? ST_SCAN1 : ST_DONE;
			end
			ST_SCAN1: begin
				if (scan_done) begin
					state_d = (vel_hit_q || have_fb_q) ? ST_SCAN2 : ST_DONE;
				end
			end
			ST_SCAN2: begin
				if (scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inst_vld_q  <= '0;
			ivld_q      <= 1'b0;
			cnt_q       <= '0;
			end_q       <= '0;
			vld_s1      <= 1'b0;
			vel_hit_q   <= 1'b0;
			have_fb_q   <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_q + 9'd1;
			end
			if (req_acc && inst_idx_ok &&
			    (req.func == FN_WR_INST_RDY || req.func == FN_WR_INST_OFF)) begin
				inst_vld_q[req.index[IW-1:0]] <= 1'b1;
			end
			if (req_acc) begin
				ivld_q <= inst_idx_ok && inst_vld_q[req.index[IW-1:0]];
			end
			case (state_q)
				ST_INST_RD: begin
					cnt_q       <= {1'b0, inst_rdata.first};
					end_q       <= span_end;
					vel_hit_q   <= 1'b0;
					have_fb_q   <= 1'b0;
					count_q     <= '0;
				end
				ST_SCAN1: begin
					if (vld_s1 && ev.cov) begin
						if (!have_fb_q || ev.root_dist < fb_d_q) begin
							have_fb_q <= 1'b1;
						end
						if (ev.vel_ok && (!vel_hit_q || ev.root_dist < best_d_q)) begin
							vel_hit_q <= 1'b1;
						end
					end
					if (scan_done) begin
						cnt_q <= {1'b0, start_q};
					end
				end
				ST_SCAN2: begin
					if (vld_s1 && ev.cov && ev.root_eq && count_q != CNT_MAX) begin
						count_q <= count_q + 8'd1;
					end
				end
				default: ;
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[ZW-1:0];
		if (req_acc) begin
			note_q <= req.note;
			vel_q  <= req.velocity;
			res_q  <= '0;
		end
		case (state_q)
			ST_INST_RD: begin
				start_q <= inst_rdata.first;
				res_q   <= '0;
			end
			ST_SCAN1: begin
				if (vld_s1 && ev.cov) begin
					if (!have_fb_q || ev.root_dist < fb_d_q) begin
						fb_q    <= zone_rdata;
						fb_id_q <= idx_s1;
						fb_d_q  <= ev.root_dist;
					end
					if (ev.vel_ok && (!vel_hit_q || ev.root_dist < best_d_q)) begin
						best_q    <= zone_rdata;
						best_id_q <= idx_s1;
						best_d_q  <= ev.root_dist;
					end
				end
				if (scan_done) begin
					sel_q    <= vel_hit_q ? best_q : fb_q;
					sel_id_q <= vel_hit_q ? best_id_q : fb_id_q;
					res_q    <= '0;
				end
			end
			ST_SCAN2: begin
				if (scan_done) begin
					res_q <= fail ? '0 : res_ok;
				end
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/szr_checker.sv
// ----------------------------------------------------------------------------
// szr_checker
// port-level checks on the sampler zone resolver request and result channels
// ----------------------------------------------------------------------------
`include "sampler_zone_resolver_assert.svh"

module szr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input szr_pkg::rsp_beat_t rsp
);

	import szr_pkg::*;

	`SZR_ASSERT_NEXT(a_one_beat, req_valid && req_ready, !req_ready, "req taken while a beat is in flight")
	`SZR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp beat dropped or changed while stalled")
	`SZR_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp.found, rsp == '0, "failed or write result not all zero")
	`SZR_ASSERT_NOW(a_single, rsp_valid, rsp.single_layer == (rsp.layer_cnt == 8'd1), "single_layer disagrees with layer_cnt")
	`SZR_ASSERT_NOW(a_found_count, rsp_valid && rsp.found, rsp.layer_cnt != 8'd0, "found result with zero layer count")

endmodule

bind sampler_zone_resolver szr_checker u_szr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
